// ===== design/slbs_pkg.sv =====
// Shared types, constants and helpers of the spectral loudness band split.
`default_nettype none

package slbs_pkg;

	// Fixed field widths
	localparam int SAMPLE_W   = 24;
	localparam int BIN_W      = 10;
	localparam int MAG_W      = 24;
	localparam int RECIP_W    = 16;
	localparam int RECIP_FRAC = 24;
	localparam int MASK_FRAC  = 16;
	localparam int MASK_W     = MASK_FRAC + 1;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;

	// Magnitude path
	localparam int ROOT_W   = 24;
	localparam int SUMSQ_W  = 48;
	localparam int SMOOTH_W = 16;
	localparam logic [SMOOTH_W-1:0] SMOOTH_COEF = 16'd18350;  // 0.28 in Q0.16

	// Mask constants
	localparam logic [MASK_W-1:0] MASK_ONE  = MASK_W'(1) << MASK_FRAC;
	localparam logic [MASK_W-1:0] MASK_HALF = MASK_W'(1) << (MASK_FRAC - 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOUD_EDGE_LOW    = 3'd0,
		CFG_LOUD_EDGE_HIGH   = 3'd1,
		CFG_LOUD_SPAN_RECIP  = 3'd2,
		CFG_QUIET_EDGE_LOW   = 3'd3,
		CFG_QUIET_EDGE_HIGH  = 3'd4,
		CFG_QUIET_SPAN_RECIP = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [BIN_W-1:0]           bin_number;
		logic signed [SAMPLE_W-1:0] left_real;
		logic signed [SAMPLE_W-1:0] left_imag;
		logic signed [SAMPLE_W-1:0] right_real;
		logic signed [SAMPLE_W-1:0] right_imag;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] loud_left_real;
		logic signed [SAMPLE_W-1:0] loud_left_imag;
		logic signed [SAMPLE_W-1:0] loud_right_real;
		logic signed [SAMPLE_W-1:0] loud_right_imag;
		logic signed [SAMPLE_W-1:0] mid_left_real;
		logic signed [SAMPLE_W-1:0] mid_left_imag;
		logic signed [SAMPLE_W-1:0] mid_right_real;
		logic signed [SAMPLE_W-1:0] mid_right_imag;
		logic signed [SAMPLE_W-1:0] quiet_left_real;
		logic signed [SAMPLE_W-1:0] quiet_left_imag;
		logic signed [SAMPLE_W-1:0] quiet_right_real;
		logic signed [SAMPLE_W-1:0] quiet_right_imag;
	} out_item_t;

	// Bin values with imaginary parts already zeroed at DC and Nyquist
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_real;
		logic signed [SAMPLE_W-1:0] left_imag;
		logic signed [SAMPLE_W-1:0] right_real;
		logic signed [SAMPLE_W-1:0] right_imag;
	} bin_vals_t;

	// Entry of the front-to-back queue
	typedef struct packed {
		logic [MAG_W-1:0] smoothed;
		bin_vals_t        vals;
	} band_item_t;

	typedef struct packed {
		logic [MAG_W-1:0]   edge_low;
		logic [MAG_W-1:0]   edge_high;
		logic [RECIP_W-1:0] span_recip;
	} ramp_cfg_t;

	typedef struct packed {
		ramp_cfg_t loud;
		ramp_cfg_t quiet;
	} split_cfg_t;

	// Magnitude of a two's complement sample; the most negative value maps to 2^(W-1)
	function automatic logic [SAMPLE_W-1:0] abs_val(input logic signed [SAMPLE_W-1:0] v);
		return v[SAMPLE_W-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

endpackage

`default_nettype wire

// ===== design/spectral_loudness_band_split.sv =====
// Top level of the spectral loudness band split: configuration registers and part wiring.
`default_nettype none

// Splits a stream of stereo spectrum bins into loud, mid and quiet bands. One bin beat is
// accepted per clock cycle while in_stall is low; every bin gives one result beat. The front
// part computes the RMS magnitude (a square root unit pipelined one result bit per stage) and
// smooths it against the per-bin store, a memory with one read port and one write port, each
// used at most once per cycle; the back part forms the ramps, divides the weights by their sum
// in two pipelined dividers and applies the masks. A two-entry queue separates the parts so
// each can stall on its own. After reset all FFT_POINTS/2+1 entries of the bin store are
// cleared, during which in_stall is held high; configuration writes are taken at any time and
// must only be made while the block is idle.
// FFT_POINTS must be a power of two.
module spectral_loudness_band_split
	import slbs_pkg::*;
#(
	parameter int FFT_POINTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	split_cfg_t cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_LOUD_EDGE_LOW:    cfg_q.loud.edge_low    <= cfg_data;
				CFG_LOUD_EDGE_HIGH:   cfg_q.loud.edge_high   <= cfg_data;
				CFG_LOUD_SPAN_RECIP:  cfg_q.loud.span_recip  <= cfg_data[RECIP_W-1:0];
				CFG_QUIET_EDGE_LOW:   cfg_q.quiet.edge_low   <= cfg_data;
				CFG_QUIET_EDGE_HIGH:  cfg_q.quiet.edge_high  <= cfg_data;
				CFG_QUIET_SPAN_RECIP: cfg_q.quiet.span_recip <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	logic       fq_valid, fq_stall, bq_valid, bq_stall;
	band_item_t fq_data, bq_data;

	slbs_front #(
		.FFT_POINTS(FFT_POINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (fq_valid),
		.q_stall  (fq_stall),
		.q_data   (fq_data)
	);

	slbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_stall (fq_stall),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop_stall  (bq_stall),
		.pop_data   (bq_data)
	);

	slbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (bq_valid),
		.q_stall   (bq_stall),
		.q_data    (bq_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== design/slbs_front.sv =====
// Front part: bin intake, stereo RMS magnitude, per-bin smoothing with the bin store.
`default_nettype none

module slbs_front
	import slbs_pkg::*;
#(
	parameter int FFT_POINTS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       q_valid,
	input  logic       q_stall,
	output band_item_t q_data
);

	localparam int BINS      = FFT_POINTS / 2 + 1;
	localparam int NYQ       = FFT_POINTS / 2;
	localparam int AW        = $clog2(BINS);
	localparam int MAG_SHIFT = $clog2(FFT_POINTS) - 2;
	localparam int TOT_W     = SUMSQ_W + 1;
	localparam int REM_W     = SUMSQ_W + 2;
	localparam int PW        = MAG_W + SMOOTH_W + 1;
	localparam logic signed [PW-1:0] SMOOTH_RND = PW'(1) <<< (SMOOTH_W - 1);

	logic adv, take;

	// Clearing pass over the bin store after reset
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(BINS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Stage 1: classify the bin
	logic             is_edge, in_range;
	logic             v_s1, ok_s1;
	logic [BIN_W-1:0] bin_s1;
	bin_vals_t        vals_s1;

	assign is_edge  = (in_data.bin_number == '0) || (32'(in_data.bin_number) == 32'(NYQ));
	assign in_range = 32'(in_data.bin_number) < 32'(BINS);
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s1             <= in_data.bin_number;
			ok_s1              <= in_range;
			vals_s1.left_real  <= in_data.left_real;
			vals_s1.left_imag  <= is_edge ? '0 : in_data.left_imag;
			vals_s1.right_real <= in_data.right_real;
			vals_s1.right_imag <= is_edge ? '0 : in_data.right_imag;
		end
	end

	// Stage 2: squares of the four parts
	logic               v_s2, ok_s2;
	logic [BIN_W-1:0]   bin_s2;
	bin_vals_t          vals_s2;
	logic [SUMSQ_W-1:0] sq_s2 [4];
	logic [SAMPLE_W-1:0] mag_in [4];

	assign mag_in[0] = abs_val(vals_s1.left_real);
	assign mag_in[1] = abs_val(vals_s1.left_imag);
	assign mag_in[2] = abs_val(vals_s1.right_real);
	assign mag_in[3] = abs_val(vals_s1.right_imag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s2  <= bin_s1;
			ok_s2   <= ok_s1;
			vals_s2 <= vals_s1;
			for (int k = 0; k < 4; k++) begin
				sq_s2[k] <= SUMSQ_W'(mag_in[k]) * SUMSQ_W'(mag_in[k]);
			end
		end
	end

	// Stage 3: square root, one result bit per step
	logic               rt_v_s3    [ROOT_W+1];
	logic               rt_ok_s3   [ROOT_W+1];
	logic [BIN_W-1:0]   rt_bin_s3  [ROOT_W+1];
	bin_vals_t          rt_vals_s3 [ROOT_W+1];
	logic [REM_W-1:0]   rt_rem_s3  [ROOT_W+1];
	logic [ROOT_W-1:0]  rt_root_s3 [ROOT_W+1];
	logic [TOT_W-1:0]   sq_total;

	assign sq_total = TOT_W'(sq_s2[0]) + TOT_W'(sq_s2[1]) + TOT_W'(sq_s2[2]) + TOT_W'(sq_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v_s3[0] <= 1'b0;
		else if (adv) rt_v_s3[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_ok_s3[0]   <= ok_s2;
			rt_bin_s3[0]  <= bin_s2;
			rt_vals_s3[0] <= vals_s2;
			rt_rem_s3[0]  <= REM_W'(sq_total[TOT_W-1:1]);
			rt_root_s3[0] <= '0;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		localparam int B = ROOT_W - 1 - k;
		logic [REM_W-1:0] trial;
		logic             fits;

		// (root + 2^B)^2 - root^2 against the remainder
		assign trial = (REM_W'(rt_root_s3[k]) << (B + 1)) | (REM_W'(1) << (2 * B));
		assign fits  = rt_rem_s3[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s3[k+1] <= 1'b0;
			else if (adv) rt_v_s3[k+1] <= rt_v_s3[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_ok_s3[k+1]   <= rt_ok_s3[k];
				rt_bin_s3[k+1]  <= rt_bin_s3[k];
				rt_vals_s3[k+1] <= rt_vals_s3[k];
				rt_rem_s3[k+1]  <= fits ? rt_rem_s3[k] - trial : rt_rem_s3[k];
				rt_root_s3[k+1] <= fits ? (rt_root_s3[k] | (ROOT_W'(1) << B)) : rt_root_s3[k];
			end
		end
	end

	// Stage 4: bin store read, smoothing, write back
	logic             v_s4, ok_s4;
	logic [BIN_W-1:0] bin_s4;
	bin_vals_t        vals_s4;
	logic [MAG_W-1:0] mag_s4, rd_s4;
	logic [MAG_W-1:0] mag_mem [BINS];
	logic [AW-1:0]    rd_addr, mem_wa;
	logic             mem_we, push;
	logic [MAG_W-1:0] mem_wd;

	assign rd_addr = rt_ok_s3[ROOT_W] ? AW'(rt_bin_s3[ROOT_W]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= rt_v_s3[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s4   <= rt_ok_s3[ROOT_W];
			bin_s4  <= rt_bin_s3[ROOT_W];
			vals_s4 <= rt_vals_s3[ROOT_W];
			mag_s4  <= MAG_W'(rt_root_s3[ROOT_W] >> MAG_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mag_mem[mem_wa] <= mem_wd;
		if (adv) rd_s4 <= mag_mem[rd_addr];
	end

	// Last write, forwarded when the same bin follows before the store shows it
	logic             lw_v_q;
	logic [BIN_W-1:0] lw_bin_q;
	logic [MAG_W-1:0] lw_val_q;
	logic             fwd;
	logic [MAG_W-1:0] prev, sm;
	logic signed [MAG_W:0]  diff;
	logic signed [PW-1:0]   prod, rnd, step;

	assign fwd  = lw_v_q && (lw_bin_q == bin_s4);
	assign prev = !ok_s4 ? '0 : (fwd ? lw_val_q : rd_s4);
	assign diff = $signed({1'b0, mag_s4}) - $signed({1'b0, prev});
	assign prod = PW'(diff) * PW'($signed({1'b0, SMOOTH_COEF}));
	assign rnd  = prod + SMOOTH_RND;
	assign step = rnd >>> SMOOTH_W;
	assign sm   = prev + step[MAG_W-1:0];

	assign push   = v_s4 && !q_stall;
	assign mem_we = clearing_q || (push && ok_s4);
	assign mem_wa = clearing_q ? clr_addr_q : AW'(bin_s4);
	assign mem_wd = clearing_q ? '0 : sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lw_v_q <= 1'b0;
		else if (push && ok_s4) lw_v_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (push && ok_s4) begin
			lw_bin_q <= bin_s4;
			lw_val_q <= sm;
		end
	end

	// Handshakes
	assign adv           = !v_s4 || !q_stall;
	assign in_stall      = clearing_q || !adv;
	assign q_valid       = v_s4;
	assign q_data.smoothed = sm;
	assign q_data.vals   = vals_s4;

endmodule

`default_nettype wire

// ===== design/slbs_queue.sv =====
// Short queue between the front and the back part.
`default_nettype none

module slbs_queue
	import slbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_stall,
	input  band_item_t push_data,
	output logic       pop_valid,
	input  logic       pop_stall,
	output band_item_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	band_item_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop;

	assign push_stall = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== design/slbs_back.sv =====
// Back part: smoothstep ramps, band mask renormalization and mask application.
`default_nettype none

module slbs_back
	import slbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  split_cfg_t cfg,
	input  logic       q_valid,
	output logic       q_stall,
	input  band_item_t q_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	localparam int PRD_W = MAG_W + RECIP_W;
	localparam int SQ_W  = 2 * MASK_W;
	localparam int CB_W  = 2 * MASK_W + 1;
	localparam int SUM_W = MASK_W + 1;
	localparam int DIV_W = 2 * MASK_W;
	localparam int APP_W = SAMPLE_W + MASK_W;
	localparam logic [SUM_W-1:0] THREE_ONE = SUM_W'(3) << MASK_FRAC;

	// Ramp position, clamped to one
	function automatic logic [MASK_W-1:0] ramp_pos(input logic [MAG_W-1:0] m,
			input ramp_cfg_t c);
		logic [PRD_W-1:0] p;
		logic [PRD_W-1:0] t;
		p = PRD_W'(m - c.edge_low) * PRD_W'(c.span_recip);
		t = p >> (RECIP_FRAC - MASK_FRAC);
		return (t > PRD_W'(MASK_ONE)) ? MASK_ONE : t[MASK_W-1:0];
	endfunction

	// t*t rounded
	function automatic logic [MASK_W-1:0] sq_round(input logic [MASK_W-1:0] t);
		logic [SQ_W-1:0] p;
		p = SQ_W'(t) * SQ_W'(t) + SQ_W'(MASK_HALF);
		return p[MASK_FRAC +: MASK_W];
	endfunction

	// t2*(3 - 2t) rounded
	function automatic logic [MASK_W-1:0] cube_round(input logic [MASK_W-1:0] t2,
			input logic [MASK_W-1:0] t);
		logic [CB_W-1:0] p;
		p = CB_W'(t2) * CB_W'(THREE_ONE - {t, 1'b0}) + CB_W'(MASK_HALF);
		return p[MASK_FRAC +: MASK_W];
	endfunction

	logic adv, take;

	assign adv     = !out_valid || !out_stall;
	assign q_stall = !adv;
	assign take    = q_valid && adv;

	// Stage 1: ramp positions and edge tests
	logic              v_s1;
	bin_vals_t         vals_s1;
	logic [MASK_W-1:0] tl_s1, tq_s1;
	logic              lo_l_s1, hi_l_s1, lo_q_s1, hi_q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vals_s1 <= q_data.vals;
			tl_s1   <= ramp_pos(q_data.smoothed, cfg.loud);
			tq_s1   <= ramp_pos(q_data.smoothed, cfg.quiet);
			lo_l_s1 <= q_data.smoothed <= cfg.loud.edge_low;
			hi_l_s1 <= q_data.smoothed >= cfg.loud.edge_high;
			lo_q_s1 <= q_data.smoothed <= cfg.quiet.edge_low;
			hi_q_s1 <= q_data.smoothed >= cfg.quiet.edge_high;
		end
	end

	// Stage 2: squares
	logic              v_s2;
	bin_vals_t         vals_s2;
	logic [MASK_W-1:0] tl_s2, tq_s2, tl2_s2, tq2_s2;
	logic              lo_l_s2, hi_l_s2, lo_q_s2, hi_q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vals_s2 <= vals_s1;
			tl_s2   <= tl_s1;
			tq_s2   <= tq_s1;
			tl2_s2  <= sq_round(tl_s1);
			tq2_s2  <= sq_round(tq_s1);
			lo_l_s2 <= lo_l_s1;
			hi_l_s2 <= hi_l_s1;
			lo_q_s2 <= lo_q_s1;
			hi_q_s2 <= hi_q_s1;
		end
	end

	// Stage 3: smoothstep and edge selection
	logic              v_s3;
	bin_vals_t         vals_s3;
	logic [MASK_W-1:0] rl_s3, rq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vals_s3 <= vals_s2;
			rl_s3   <= lo_l_s2 ? '0 : (hi_l_s2 ? MASK_ONE : cube_round(tl2_s2, tl_s2));
			rq_s3   <= lo_q_s2 ? '0 : (hi_q_s2 ? MASK_ONE : cube_round(tq2_s2, tq_s2));
		end
	end

	// Band weights and their sum
	logic [MASK_W-1:0] loud, quiet, mid;
	logic [SUM_W-1:0]  lq_sum, w_sum;

	assign loud   = rl_s3;
	assign quiet  = MASK_ONE - rq_s3;
	assign lq_sum = SUM_W'(loud) + SUM_W'(quiet);
	assign mid    = (lq_sum < SUM_W'(MASK_ONE)) ? MASK_W'(SUM_W'(MASK_ONE) - lq_sum) : '0;
	assign w_sum  = lq_sum + SUM_W'(mid);

	// Stage 4: renormalizing dividers, lane 0 loud and lane 1 quiet, one quotient bit a step.
	// A sum of exactly one divides to the same value; mid is zero whenever the sum is not one.
	logic              dv_v_s4    [MASK_W+1];
	bin_vals_t         dv_vals_s4 [MASK_W+1];
	logic [MASK_W-1:0] dv_mid_s4  [MASK_W+1];
	logic [SUM_W-1:0]  dv_sum_s4  [MASK_W+1];
	logic [DIV_W-1:0]  dv_rem_s4  [2][MASK_W+1];
	logic [MASK_W-1:0] dv_quo_s4  [2][MASK_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s4[0] <= 1'b0;
		else if (adv) dv_v_s4[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_vals_s4[0]   <= vals_s3;
			dv_mid_s4[0]    <= mid;
			dv_sum_s4[0]    <= w_sum;
			dv_rem_s4[0][0] <= (DIV_W'(loud) << MASK_FRAC) + DIV_W'(w_sum >> 1);
			dv_rem_s4[1][0] <= (DIV_W'(quiet) << MASK_FRAC) + DIV_W'(w_sum >> 1);
			dv_quo_s4[0][0] <= '0;
			dv_quo_s4[1][0] <= '0;
		end
	end

	for (genvar k = 0; k < MASK_W; k++) begin : g_div
		localparam int B = MASK_W - 1 - k;
		logic [DIV_W-1:0] trial;

		assign trial = DIV_W'(dv_sum_s4[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s4[k+1] <= 1'b0;
			else if (adv) dv_v_s4[k+1] <= dv_v_s4[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_vals_s4[k+1] <= dv_vals_s4[k];
				dv_mid_s4[k+1]  <= dv_mid_s4[k];
				dv_sum_s4[k+1]  <= dv_sum_s4[k];
			end
		end

		for (genvar n = 0; n < 2; n++) begin : g_lane
			logic fits;

			assign fits = dv_rem_s4[n][k] >= trial;

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s4[n][k+1] <= fits ? dv_rem_s4[n][k] - trial : dv_rem_s4[n][k];
					dv_quo_s4[n][k+1] <= fits ? (dv_quo_s4[n][k] | (MASK_W'(1) << B))
						: dv_quo_s4[n][k];
				end
			end
		end
	end

	// Stage 5: part magnitude times mask, band-major order loud, mid, quiet
	logic signed [SAMPLE_W-1:0] part [4];
	logic [MASK_W-1:0]          mask [3];
	logic                       v_s5;
	logic [APP_W-1:0]           prod_s5 [12];
	logic                       neg_s5  [12];

	assign part[0] = dv_vals_s4[MASK_W].left_real;
	assign part[1] = dv_vals_s4[MASK_W].left_imag;
	assign part[2] = dv_vals_s4[MASK_W].right_real;
	assign part[3] = dv_vals_s4[MASK_W].right_imag;
	assign mask[0] = dv_quo_s4[0][MASK_W];
	assign mask[1] = dv_mid_s4[MASK_W];
	assign mask[2] = dv_quo_s4[1][MASK_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= dv_v_s4[MASK_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int b = 0; b < 3; b++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s5[b*4+c] <= APP_W'(abs_val(part[c])) * APP_W'(mask[b]);
					neg_s5[b*4+c]  <= part[c][SAMPLE_W-1];
				end
			end
		end
	end

	// Stage 6: round half away from zero, output register
	logic                       v_s6;
	logic signed [SAMPLE_W-1:0] res_s6 [12];
	logic [APP_W-1:0]           rnd [12];

	for (genvar j = 0; j < 12; j++) begin : g_rnd
		assign rnd[j] = prod_s5[j] + APP_W'(MASK_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 12; j++) begin
				res_s6[j] <= neg_s5[j] ? -signed'(rnd[j][MASK_FRAC +: SAMPLE_W])
					: signed'(rnd[j][MASK_FRAC +: SAMPLE_W]);
			end
		end
	end

	assign out_valid                 = v_s6;
	assign out_data.loud_left_real   = res_s6[0];
	assign out_data.loud_left_imag   = res_s6[1];
	assign out_data.loud_right_real  = res_s6[2];
	assign out_data.loud_right_imag  = res_s6[3];
	assign out_data.mid_left_real    = res_s6[4];
	assign out_data.mid_left_imag    = res_s6[5];
	assign out_data.mid_right_real   = res_s6[6];
	assign out_data.mid_right_imag   = res_s6[7];
	assign out_data.quiet_left_real  = res_s6[8];
	assign out_data.quiet_left_imag  = res_s6[9];
	assign out_data.quiet_right_real = res_s6[10];
	assign out_data.quiet_right_imag = res_s6[11];

endmodule

`default_nettype wire
